// ===== hdl/spims_pkg.sv =====
package spims_pkg;

    localparam int TX_W       = 32;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic CMD_XFER = 1'b0;
    localparam logic CMD_CS   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR      = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CS,
        ST_LEAD,
        ST_TRAIL
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic rx_en;
    } t_shift_ctl;

endpackage

// ===== hdl/spims_if.sv =====
interface spims_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [spims_pkg::TX_W-1:0]     tx_word;
    logic [spims_pkg::CNT_W-1:0]    bit_count;
    logic [spims_pkg::TX_W-1:0]     slave_bits;
    logic                           select_active;

    modport source (
        output valid, command, tx_word, bit_count, slave_bits, select_active,
        input  ready
    );
    modport sink (
        input  valid, command, tx_word, bit_count, slave_bits, select_active,
        output ready
    );
endinterface

interface spims_out_if;
    logic                       valid;
    logic                       ready;
    logic                       sck_level;
    logic                       mosi_level;
    logic                       cs_level;
    logic [spims_pkg::TX_W-1:0] rx_word;
    logic                       last;

    modport source (
        output valid, sck_level, mosi_level, cs_level, rx_word, last,
        input  ready
    );
    modport sink (
        input  valid, sck_level, mosi_level, cs_level, rx_word, last,
        output ready
    );
endinterface

interface spims_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [spims_pkg::CFG_IDX_W-1:0]   index;
    logic [spims_pkg::CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== hdl/spims_shifter.sv =====
module spims_shifter #(
    parameter int SHIFT_W = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  spims_pkg::t_shift_ctl        i_ctl,
    input  logic [spims_pkg::TX_W-1:0]   i_tx_word,
    input  logic [spims_pkg::TX_W-1:0]   i_slave_bits,
    input  logic [spims_pkg::CNT_W-1:0]  i_bit_count,
    output logic                         o_tx_bit,
    output logic                         o_last_bit,
    output logic [spims_pkg::TX_W-1:0]   o_rx_next
);
    import spims_pkg::*;

    localparam int PW = $clog2(SHIFT_W);

    logic [SHIFT_W-1:0] r_tx;
    logic [SHIFT_W-1:0] r_miso;
    logic [SHIFT_W-1:0] r_rx;
    logic [SHIFT_W-1:0] n_rx;
    logic [PW-1:0]      r_pos;
    logic [CNT_W-1:0]   w_n;

    // clamp the bit count into 1..SHIFT_W
    always_comb begin
        if (i_bit_count == '0) begin
            w_n = CNT_W'(1);
        end else if (i_bit_count > CNT_W'(SHIFT_W)) begin
            w_n = CNT_W'(SHIFT_W);
        end else begin
            w_n = i_bit_count;
        end
    end

    always_comb begin
        if (i_ctl.rx_en) begin
            n_rx = {r_rx[SHIFT_W-2:0], r_miso[r_pos]};
        end else begin
            n_rx = r_rx;
        end
    end

    assign o_tx_bit   = r_tx[r_pos];
    assign o_last_bit = (r_pos == '0);
    assign o_rx_next  = TX_W'(n_rx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_ctl.load) begin
            r_pos <= PW'(w_n - CNT_W'(1));
        end else if (i_ctl.step) begin
            r_pos <= r_pos - PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_tx   <= i_tx_word[SHIFT_W-1:0];
            r_miso <= i_slave_bits[SHIFT_W-1:0];
            r_rx   <= '0;
        end else if (i_ctl.step) begin
            r_rx <= n_rx;
        end
    end

endmodule

// ===== hdl/spims_seq.sv =====
module spims_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    spims_in_if.sink                     i_in,
    spims_out_if.source                  o_out,
    spims_cfg_if.sink                    i_cfg,
    input  logic                         i_tx_bit,
    input  logic                         i_last_bit,
    input  logic [spims_pkg::TX_W-1:0]   i_rx_next,
    output spims_pkg::t_shift_ctl        o_ctl
);
    import spims_pkg::*;

    t_state          r_state;
    t_state          n_state;
    logic            r_pol;
    logic [1:0]      r_dir;
    logic            r_sck;
    logic            r_mosi;
    logic            r_cs;
    logic            n_sck;
    logic            n_mosi;
    logic            n_cs;
    logic            r_o_valid;
    logic            r_o_sck;
    logic            r_o_mosi;
    logic            r_o_cs;
    logic [TX_W-1:0] r_o_rx;
    logic            r_o_last;
    logic            w_slot;
    logic            w_emit;
    logic [TX_W-1:0] w_rx;
    logic            w_last;

    assign w_slot      = !r_o_valid || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_sck       = r_sck;
        n_mosi      = r_mosi;
        n_cs        = r_cs;
        w_emit      = 1'b0;
        w_rx        = '0;
        w_last      = 1'b0;
        o_ctl.load  = 1'b0;
        o_ctl.step  = 1'b0;
        o_ctl.rx_en = !r_dir[1];
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.command == CMD_CS) begin
                        n_cs    = !i_in.select_active;
                        n_state = ST_CS;
                    end else begin
                        o_ctl.load = 1'b1;
                        n_state    = ST_LEAD;
                    end
                end
            end
            ST_CS: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_LEAD: begin
                if (w_slot) begin
                    n_sck = !r_pol;
                    if (!r_dir[0]) begin
                        n_mosi = i_tx_bit;
                    end
                    w_emit  = 1'b1;
                    n_state = ST_TRAIL;
                end
            end
            ST_TRAIL: begin
                if (w_slot) begin
                    n_sck      = r_pol;
                    o_ctl.step = 1'b1;
                    w_emit     = 1'b1;
                    w_last     = i_last_bit;
                    w_rx       = i_last_bit ? i_rx_next : '0;
                    n_state    = i_last_bit ? ST_IDLE : ST_LEAD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sck  <= 1'b1;
            r_mosi <= 1'b0;
            r_cs   <= 1'b1;
        end else begin
            r_sck  <= n_sck;
            r_mosi <= n_mosi;
            r_cs   <= n_cs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pol <= 1'b1;
            r_dir <= 2'b00;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_POLARITY: r_pol <= i_cfg.data[0];
                CFG_DIR:      r_dir <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_sck  <= n_sck;
            r_o_mosi <= n_mosi;
            r_o_cs   <= n_cs;
            r_o_rx   <= w_rx;
            r_o_last <= w_last;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.sck_level  = r_o_sck;
    assign o_out.mosi_level = r_o_mosi;
    assign o_out.cs_level   = r_o_cs;
    assign o_out.rx_word    = r_o_rx;
    assign o_out.last       = r_o_last;

`ifndef ASSERT_OFF
    a_lead_sck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_state == ST_LEAD) |=> (r_o_sck != r_pol))
        else $error("leading phase SCK not at active level");

    a_trail_sck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_state == ST_TRAIL) |=> (r_o_sck == r_pol && r_sck == r_pol))
        else $error("trailing phase SCK not at idle level");

    a_rx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_last) |-> (r_o_rx == '0))
        else $error("rx word nonzero on non-final item");

    a_cs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEAD || r_state == ST_TRAIL) |=> $stable(r_cs))
        else $error("CS changed during a transfer");
`endif

endmodule

// ===== hdl/spi_master_word_shifter_unit.sv =====
// Transfer item of n bits (n clamped to 1..min(MAX_BITS,32)): 2n results, one per
// pin phase; the first result is registered after the sequencer leaves idle, then
// one per cycle while output backpressure does not stall it. A new item is taken
// only in idle; pacing is set by the phase sequencer and the single bit-shift unit.
// Reset (sync, active low): SCK 1, MOSI 0, CS 1, polarity 1, direction mode 0.
module spi_master_word_shifter_unit #(
    parameter int MAX_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spims_in_if.sink     i_in,
    spims_out_if.source  o_out,
    spims_cfg_if.sink    i_cfg
);
    import spims_pkg::*;

    localparam int SHIFT_W = (MAX_BITS < TX_W) ? MAX_BITS : TX_W;

    t_shift_ctl      w_ctl;
    logic            w_tx_bit;
    logic            w_last_bit;
    logic [TX_W-1:0] w_rx_next;

    spims_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg      (i_cfg),
        .i_tx_bit   (w_tx_bit),
        .i_last_bit (w_last_bit),
        .i_rx_next  (w_rx_next),
        .o_ctl      (w_ctl)
    );

    spims_shifter #(
        .SHIFT_W (SHIFT_W)
    ) u_shifter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_tx_word    (i_in.tx_word),
        .i_slave_bits (i_in.slave_bits),
        .i_bit_count  (i_in.bit_count),
        .o_tx_bit     (w_tx_bit),
        .o_last_bit   (w_last_bit),
        .o_rx_next    (w_rx_next)
    );

endmodule
